FILE: src/vpi_pkg.sv
// ----------------------------------------------------------------------------
// vpi_pkg
// Shared types and constants of the position-Verlet particle integrator.
// ----------------------------------------------------------------------------
package vpi_pkg;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_ACCEL   = 3'd2,
        OP_SET_VEL = 3'd3,
        OP_ADD_VEL = 3'd4,
        OP_GET_VEL = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NOT_INSERTED = 2'd2
    } status_t;

    typedef struct packed {
        op_t        op;
        status_t    status;
        logic [7:0] rid;
    } ctl_t;

    localparam int          ID_WIDTH        = 8;
    localparam int          TS_WIDTH        = 16;
    localparam int          DT2_WIDTH       = 32;
    localparam int          ENTRY_WORDS     = 6;
    localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
    localparam logic [31:0] DT2_RESET       = 32'd1192464;

endpackage

FILE: src/vpi_table.sv
// ----------------------------------------------------------------------------
// vpi_table
// Particle state memory: one write port, one registered read port, with
// write-to-read forwarding for the same entry.
// ----------------------------------------------------------------------------
module vpi_table #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 144,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

FILE: src/vpi_alu.sv
// ----------------------------------------------------------------------------
// vpi_alu
// Arithmetic of the integrator: time-step scaling at accept, the dt squared
// product on the read entry, then the saturating update of one entry.
// ----------------------------------------------------------------------------
module vpi_alu
    import vpi_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                a_load,
    input  logic                                b_load,
    input  logic signed [COORD_WIDTH-1:0]       x_value,
    input  logic signed [COORD_WIDTH-1:0]       y_value,
    input  logic [TS_WIDTH-1:0]                 time_step,
    input  logic [DT2_WIDTH-1:0]                dt2,
    input  logic [ENTRY_WORDS*COORD_WIDTH-1:0]  rd_entry,
    input  ctl_t                                ctl,
    output logic                                wr_req,
    output logic [ENTRY_WORDS*COORD_WIDTH-1:0]  wr_entry,
    output logic signed [COORD_WIDTH-1:0]       res_x,
    output logic signed [COORD_WIDTH-1:0]       res_y
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = ENTRY_WORDS * CW;
    localparam int VW = CW + 1;
    localparam int SW = CW + 2;
    localparam int PW = CW + TS_WIDTH + 1;
    localparam int QW = CW + DT2_WIDTH + 1;

    localparam logic signed [SW-1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF16 = {{(PW-16){1'b0}}, 1'b1, 15'b0};
    localparam logic signed [QW-1:0] HALF32 = {{(QW-32){1'b0}}, 1'b1, 31'b0};

    function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[CW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sub_sat(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        return sat_c(SW'(a) - SW'(b));
    endfunction

    function automatic logic signed [CW-1:0] add_sat(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        return sat_c(SW'(a) + SW'(b));
    endfunction

    function automatic logic signed [VW-1:0] round32(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] r;
        r = q + HALF32;
        return r[QW-1:32];
    endfunction

    function automatic logic signed [CW-1:0] step_pos(input logic signed [CW-1:0] pos,
                                                      input logic signed [CW-1:0] prev,
                                                      input logic signed [QW-1:0] q);
        logic signed [CW-1:0] d;
        logic signed [VW-1:0] ar;
        logic signed [CW-1:0] v;
        d  = sub_sat(VW'(pos), VW'(prev));
        ar = round32(q);
        v  = sat_c(SW'(d) + SW'(ar));
        return add_sat(VW'(pos), VW'(v));
    endfunction

    // accept stage
    logic signed [PW-1:0] prod_vx;
    logic signed [PW-1:0] prod_vy;
    logic signed [PW-1:0] rnd_vx;
    logic signed [PW-1:0] rnd_vy;

    logic signed [CW-1:0] b_xv_reg;
    logic signed [CW-1:0] b_yv_reg;
    logic signed [VW-1:0] b_vdx_reg;
    logic signed [VW-1:0] b_vdy_reg;

    assign prod_vx = PW'(x_value) * PW'($signed({1'b0, time_step}));
    assign prod_vy = PW'(y_value) * PW'($signed({1'b0, time_step}));
    assign rnd_vx  = prod_vx + HALF16;
    assign rnd_vy  = prod_vy + HALF16;

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            b_xv_reg  <= x_value;
            b_yv_reg  <= y_value;
            b_vdx_reg <= rnd_vx[PW-1:16];
            b_vdy_reg <= rnd_vy[PW-1:16];
        end
    end

    // read stage
    logic signed [CW-1:0] rd_acc_x;
    logic signed [CW-1:0] rd_acc_y;
    logic signed [QW-1:0] prod_ax;
    logic signed [QW-1:0] prod_ay;

    logic [EW-1:0]        c_entry_reg;
    logic signed [CW-1:0] c_xv_reg;
    logic signed [CW-1:0] c_yv_reg;
    logic signed [VW-1:0] c_vdx_reg;
    logic signed [VW-1:0] c_vdy_reg;
    logic signed [QW-1:0] c_qx_reg;
    logic signed [QW-1:0] c_qy_reg;

    assign rd_acc_x = rd_entry[4*CW +: CW];
    assign rd_acc_y = rd_entry[5*CW +: CW];
    assign prod_ax  = QW'(rd_acc_x) * QW'($signed({1'b0, dt2}));
    assign prod_ay  = QW'(rd_acc_y) * QW'($signed({1'b0, dt2}));

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            c_entry_reg <= rd_entry;
            c_xv_reg    <= b_xv_reg;
            c_yv_reg    <= b_yv_reg;
            c_vdx_reg   <= b_vdx_reg;
            c_vdy_reg   <= b_vdy_reg;
            c_qx_reg    <= prod_ax;
            c_qy_reg    <= prod_ay;
        end
    end

    // write-back stage
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] prev_x;
    logic signed [CW-1:0] prev_y;
    logic signed [CW-1:0] acc_x;
    logic signed [CW-1:0] acc_y;
    logic signed [CW-1:0] np_x;
    logic signed [CW-1:0] np_y;

    assign pos_x  = c_entry_reg[0*CW +: CW];
    assign pos_y  = c_entry_reg[1*CW +: CW];
    assign prev_x = c_entry_reg[2*CW +: CW];
    assign prev_y = c_entry_reg[3*CW +: CW];
    assign acc_x  = c_entry_reg[4*CW +: CW];
    assign acc_y  = c_entry_reg[5*CW +: CW];
    assign np_x   = step_pos(pos_x, prev_x, c_qx_reg);
    assign np_y   = step_pos(pos_y, prev_y, c_qy_reg);

    always_comb
    begin
        wr_req   = 1'b0;
        wr_entry = c_entry_reg;
        res_x    = '0;
        res_y    = '0;
        if (ctl.status == ST_OK)
        begin
            case (ctl.op)
                OP_INSERT:
                begin
                    wr_req   = 1'b1;
                    wr_entry = {{(2*CW){1'b0}}, c_yv_reg, c_xv_reg, c_yv_reg, c_xv_reg};
                end
                OP_UPDATE:
                begin
                    wr_req   = 1'b1;
                    wr_entry = {{(2*CW){1'b0}}, pos_y, pos_x, np_y, np_x};
                    res_x    = np_x;
                    res_y    = np_y;
                end
                OP_ACCEL:
                begin
                    wr_req   = 1'b1;
                    wr_entry = {add_sat(VW'(acc_y), VW'(c_yv_reg)),
                                add_sat(VW'(acc_x), VW'(c_xv_reg)),
                                prev_y, prev_x, pos_y, pos_x};
                end
                OP_SET_VEL:
                begin
                    wr_req   = 1'b1;
                    wr_entry = {acc_y, acc_x,
                                sub_sat(VW'(pos_y), c_vdy_reg),
                                sub_sat(VW'(pos_x), c_vdx_reg),
                                pos_y, pos_x};
                end
                OP_ADD_VEL:
                begin
                    wr_req   = 1'b1;
                    wr_entry = {acc_y, acc_x,
                                sub_sat(VW'(prev_y), c_vdy_reg),
                                sub_sat(VW'(prev_x), c_vdx_reg),
                                pos_y, pos_x};
                end
                OP_GET_VEL:
                begin
                    res_x = sub_sat(VW'(pos_x), VW'(prev_x));
                    res_y = sub_sat(VW'(pos_y), VW'(prev_y));
                end
                default:
                begin
                    wr_req = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: src/verlet_particle_integrator_top.sv
// ----------------------------------------------------------------------------
// verlet_particle_integrator_top
// Position-Verlet particle table with insert, update, accelerate and
// velocity operations on saturating signed Q16.8 coordinates.
//
// Input channel: in_valid / in_stall with op, particle_id, x_value, y_value.
// Output channel: out_valid / out_stall with result_id, out_x, out_y, status.
// Every accepted item yields exactly one result item.
// Configuration: cfg_wr_en / cfg_wr_data load the time step; write only
// while no item is in flight.
// An item passes the read and write-back stages, then the output register.
// Items wait for the read-modify-write of the particle memory (read at
// accept, multiply, write back): none is taken while one is in the read stage.
// Reset clears the particle count and loads the default time step; the
// particle memory is not cleared, entries beyond the count are never used.
// When the receiver stalls, the result holds in the output register, the
// next item waits in the write-back stage and in_stall rises.
// ----------------------------------------------------------------------------
module verlet_particle_integrator_top
    import vpi_pkg::*;
#(
    parameter int MAX_PARTICLES = 256,
    parameter int COORD_WIDTH   = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic [ID_WIDTH-1:0]           particle_id,
    input  logic signed [COORD_WIDTH-1:0] x_value,
    input  logic signed [COORD_WIDTH-1:0] y_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ID_WIDTH-1:0]           result_id,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic [1:0]                    status,
    input  logic                          cfg_wr_en,
    input  logic [TS_WIDTH-1:0]           cfg_wr_data
);

    localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNTW = $clog2(MAX_PARTICLES + 1);
    localparam int CMPW = (CNTW > ID_WIDTH) ? CNTW : ID_WIDTH;
    localparam int EW   = ENTRY_WORDS * COORD_WIDTH;

    logic                   b_valid_reg;
    logic                   b_valid_next;
    logic                   c_valid_reg;
    logic                   c_valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    op_t                    b_op_reg;
    logic [ID_WIDTH-1:0]    b_id_reg;
    ctl_t                   b_ctl;
    ctl_t                   c_ctl_reg;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        count_next;
    logic [TS_WIDTH-1:0]    time_step_reg;
    logic [DT2_WIDTH-1:0]   dt2_reg;

    logic [ID_WIDTH-1:0]    result_id_reg;
    logic [COORD_WIDTH-1:0] out_x_reg;
    logic [COORD_WIDTH-1:0] out_y_reg;
    status_t                status_reg;

    logic                   accept;
    logic                   b_move;
    logic                   c_done;
    logic                   wr_req;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_entry;
    logic [EW-1:0]          rd_entry;
    logic signed [COORD_WIDTH-1:0] res_x;
    logic signed [COORD_WIDTH-1:0] res_y;

    assign c_done   = c_valid_reg && (!out_valid_reg || !out_stall);
    assign b_move   = b_valid_reg && (!c_valid_reg || c_done);
    assign in_stall = b_valid_reg || (c_valid_reg && !c_done);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        b_valid_next   = accept ? 1'b1 : (b_move ? 1'b0 : b_valid_reg);
        c_valid_next   = b_move ? 1'b1 : (c_done ? 1'b0 : c_valid_reg);
        out_valid_next = c_done || (out_valid_reg && out_stall);
        count_next     = count_reg;
        if (c_done && (c_ctl_reg.op == OP_INSERT) && (c_ctl_reg.status == ST_OK))
        begin
            count_next = count_reg + CNTW'(1);
        end
    end

    always_comb
    begin
        b_ctl.op     = b_op_reg;
        b_ctl.status = ST_OK;
        b_ctl.rid    = b_id_reg;
        case (b_op_reg)
            OP_INSERT:
            begin
                if (count_reg < CNTW'(MAX_PARTICLES))
                begin
                    b_ctl.rid = ID_WIDTH'(count_reg);
                end
                else
                begin
                    b_ctl.status = ST_FULL;
                    b_ctl.rid    = '0;
                end
            end
            OP_UPDATE, OP_ACCEL, OP_SET_VEL, OP_ADD_VEL, OP_GET_VEL:
            begin
                if (CMPW'(b_id_reg) >= CMPW'(count_reg))
                begin
                    b_ctl.status = ST_NOT_INSERTED;
                end
            end
            default:
            begin
                b_ctl.status = ST_OK;
            end
        endcase
    end

    assign wr_en   = c_done && wr_req;
    assign wr_addr = (c_ctl_reg.op == OP_INSERT) ? count_reg[AW-1:0] : AW'(c_ctl_reg.rid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            time_step_reg <= TIME_STEP_RESET;
            dt2_reg       <= DT2_RESET;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_wr_en)
            begin
                time_step_reg <= cfg_wr_data;
                dt2_reg       <= DT2_WIDTH'(cfg_wr_data) * DT2_WIDTH'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_op_reg <= op_t'(op);
            b_id_reg <= particle_id;
        end
        if (b_move)
        begin
            c_ctl_reg <= b_ctl;
        end
        if (c_done)
        begin
            result_id_reg <= c_ctl_reg.rid;
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            status_reg    <= c_ctl_reg.status;
        end
    end

    vpi_table #(
        .DEPTH (MAX_PARTICLES),
        .WIDTH (EW)
    ) u_table (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (AW'(particle_id)),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    vpi_alu #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_alu (
        .clk       (clk),
        .a_load    (accept),
        .b_load    (b_move),
        .x_value   (x_value),
        .y_value   (y_value),
        .time_step (time_step_reg),
        .dt2       (dt2_reg),
        .rd_entry  (rd_entry),
        .ctl       (c_ctl_reg),
        .wr_req    (wr_req),
        .wr_entry  (wr_entry),
        .res_x     (res_x),
        .res_y     (res_y)
    );

    assign out_valid = out_valid_reg;
    assign result_id = result_id_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign status    = status_reg;

endmodule

FILE: dv/verlet_particle_integrator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// verlet_particle_integrator_top_tb
// Self-checking bench for the position-Verlet particle table. A directed
// table covers the edges: empty table, extreme coordinates, spare opcodes,
// saturation and unknown ids. It is followed by random traffic under several
// time steps, a fill up to a full table and inserts beyond it. A local
// fixed-point model predicts the result of every untyped row. Bursty input
// and a patterned output stall with one long hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module verlet_particle_integrator_top_tb;
    import vpi_pkg::*;

    localparam int                 TABLE_DEPTH = 256;
    localparam logic signed [23:0] CMAX        = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN        = 24'sh800000;
    localparam logic [2:0]         OP_SPARE_6  = 3'd6;
    localparam logic [2:0]         OP_SPARE_7  = 3'd7;

    typedef struct packed {
        logic [ID_WIDTH-1:0] rid;
        logic signed [23:0]  x;
        logic signed [23:0]  y;
        logic [1:0]          st;
    } result_t;

    typedef struct packed {
        logic [2:0]          op;
        logic [ID_WIDTH-1:0] id;
        logic signed [23:0]  x;
        logic signed [23:0]  y;
        logic                typed;
        result_t             want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [2:0]          op;
    logic [ID_WIDTH-1:0] particle_id;
    logic signed [23:0]  x_value;
    logic signed [23:0]  y_value;
    logic                out_valid;
    logic                out_stall;
    logic [ID_WIDTH-1:0] result_id;
    logic signed [23:0]  out_x;
    logic signed [23:0]  out_y;
    logic [1:0]          status;
    logic                cfg_wr_en;
    logic [TS_WIDTH-1:0] cfg_wr_data;

    int          pos_x  [0:TABLE_DEPTH-1];
    int          pos_y  [0:TABLE_DEPTH-1];
    int          prev_x [0:TABLE_DEPTH-1];
    int          prev_y [0:TABLE_DEPTH-1];
    int          acc_x  [0:TABLE_DEPTH-1];
    int          acc_y  [0:TABLE_DEPTH-1];
    int          particle_total;
    logic [15:0] step_q16;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];
    result_t     oldest_result;
    int          fail_count;
    int          burst_left;
    int          hold_requests;
    int          hold_served;

    verlet_particle_integrator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .particle_id (particle_id),
        .x_value     (x_value),
        .y_value     (y_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_id   (result_id),
        .out_x       (out_x),
        .out_y       (out_y),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_coord(input longint v);
        if (v > longint'(CMAX))
            return int'(CMAX);
        if (v < longint'(CMIN))
            return int'(CMIN);
        return int'(v);
    endfunction

    function automatic longint scale_by_step(input int v);
        longint ts;
        longint p;
        ts = step_q16;
        p  = longint'(v) * ts;
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint scale_by_step_sq(input int a);
        longint ts;
        longint p;
        ts = step_q16;
        p  = longint'(a) * (ts * ts);
        return (p + 64'sd2147483648) >>> 32;
    endfunction

    function automatic result_t integrate_item(input logic [2:0] opc,
                                               input logic [ID_WIDTH-1:0] id,
                                               input logic signed [23:0] xv,
                                               input logic signed [23:0] yv);
        result_t r;
        int      vx;
        int      vy;
        r.rid = id;
        r.x   = '0;
        r.y   = '0;
        r.st  = ST_OK;
        if (opc == OP_INSERT)
        begin
            if (particle_total < TABLE_DEPTH)
            begin
                pos_x[particle_total]  = xv;
                pos_y[particle_total]  = yv;
                prev_x[particle_total] = xv;
                prev_y[particle_total] = yv;
                acc_x[particle_total]  = 0;
                acc_y[particle_total]  = 0;
                r.rid = particle_total[7:0];
                particle_total++;
            end
            else
            begin
                r.rid = '0;
                r.st  = ST_FULL;
            end
        end
        else if (opc > OP_GET_VEL)
        begin
            r.st = ST_OK;
        end
        else if (int'(id) >= particle_total)
        begin
            r.st = ST_NOT_INSERTED;
        end
        else
        begin
            case (opc)
                OP_UPDATE:
                begin
                    vx = clamp_coord(longint'(clamp_coord(longint'(pos_x[id]) - prev_x[id]))
                                     + scale_by_step_sq(acc_x[id]));
                    vy = clamp_coord(longint'(clamp_coord(longint'(pos_y[id]) - prev_y[id]))
                                     + scale_by_step_sq(acc_y[id]));
                    prev_x[id] = pos_x[id];
                    prev_y[id] = pos_y[id];
                    pos_x[id]  = clamp_coord(longint'(pos_x[id]) + vx);
                    pos_y[id]  = clamp_coord(longint'(pos_y[id]) + vy);
                    acc_x[id]  = 0;
                    acc_y[id]  = 0;
                    r.x = pos_x[id][23:0];
                    r.y = pos_y[id][23:0];
                end
                OP_ACCEL:
                begin
                    acc_x[id] = clamp_coord(longint'(acc_x[id]) + longint'(xv));
                    acc_y[id] = clamp_coord(longint'(acc_y[id]) + longint'(yv));
                end
                OP_SET_VEL:
                begin
                    prev_x[id] = clamp_coord(longint'(pos_x[id]) - scale_by_step(xv));
                    prev_y[id] = clamp_coord(longint'(pos_y[id]) - scale_by_step(yv));
                end
                OP_ADD_VEL:
                begin
                    prev_x[id] = clamp_coord(longint'(prev_x[id]) - scale_by_step(xv));
                    prev_y[id] = clamp_coord(longint'(prev_y[id]) - scale_by_step(yv));
                end
                default:
                begin
                    vx  = clamp_coord(longint'(pos_x[id]) - prev_x[id]);
                    vy  = clamp_coord(longint'(pos_y[id]) - prev_y[id]);
                    r.x = vx[23:0];
                    r.y = vy[23:0];
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [23:0] pick_coord(input int unsigned spread);
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return CMAX;
        if (sel == 1)
            return CMIN;
        if (sel <= 3)
            v = $urandom();
        else
            v = int'($urandom_range(0, 2 << spread)) - (1 << spread);
        return v[23:0];
    endfunction

    task automatic add_row(input logic [2:0] opc, input logic [ID_WIDTH-1:0] id,
                           input logic signed [23:0] xv, input logic signed [23:0] yv,
                           input logic typed, input logic [ID_WIDTH-1:0] rid,
                           input logic signed [23:0] ex, input logic signed [23:0] ey,
                           input logic [1:0] st);
        stim_row_t row;
        row.op        = opc;
        row.id        = id;
        row.x         = xv;
        row.y         = yv;
        row.typed     = typed;
        row.want.rid  = rid;
        row.want.x    = ex;
        row.want.y    = ey;
        row.want.st   = st;
        directed_rows = {directed_rows, row};
    endtask

    task automatic offer(input stim_row_t row);
        result_t     predicted;
        int unsigned gap;
        @(negedge clk);
        in_valid    = 1'b1;
        op          = row.op;
        particle_id = row.id;
        x_value     = row.x;
        y_value     = row.y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = integrate_item(row.op, row.id, row.x, row.y);
        if (row.typed)
            predicted = row.want;
        pending_results = {pending_results, predicted};
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic offer_random(input int unsigned insert_pct);
        stim_row_t   row;
        int unsigned op_pick;
        row = '0;
        row.id = ID_WIDTH'($urandom());
        if ($urandom_range(0, 99) < insert_pct)
        begin
            row.op = OP_INSERT;
            row.x  = pick_coord(18);
            row.y  = pick_coord(18);
        end
        else
        begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 25)
                row.op = OP_UPDATE;
            else if (op_pick < 50)
                row.op = OP_ACCEL;
            else if (op_pick < 62)
                row.op = OP_SET_VEL;
            else if (op_pick < 74)
                row.op = OP_ADD_VEL;
            else if (op_pick < 95)
                row.op = OP_GET_VEL;
            else if (op_pick < 98)
                row.op = OP_SPARE_6;
            else
                row.op = OP_SPARE_7;
            if (particle_total > 0 && $urandom_range(0, 99) < 88)
                row.id = ID_WIDTH'($urandom_range(0, particle_total - 1));
            row.x = pick_coord(row.op == OP_ACCEL ? 20 : 16);
            row.y = pick_coord(row.op == OP_ACCEL ? 20 : 16);
        end
        offer(row);
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_step(input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        step_q16    = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: id=%0d x=%0d y=%0d status=%0d",
                             result_id, out_x, out_y, status);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result_id !== oldest_result.rid || out_x !== oldest_result.x ||
                    out_y !== oldest_result.y || status !== oldest_result.st)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected id=%0d x=%0d y=%0d status=%0d,",
                                  " got id=%0d x=%0d y=%0d status=%0d"},
                                 oldest_result.rid, oldest_result.x, oldest_result.y,
                                 oldest_result.st, result_id, out_x, out_y, status);
                end
            end
        end
    end

    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        out_stall = 1'b0;
        forever
        begin
            if (hold_requests != hold_served)
            begin
                hold_served++;
                for (k = 0; k < 60; k++)
                begin
                    @(negedge clk);
                    out_stall = 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 30);
                for (k = 0; k < span; k++)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       out_stall = 1'b0;
                        1:       out_stall = ($urandom_range(0, 1) == 1);
                        2:       out_stall = (k % 4 == 1 || k % 4 == 2);
                        default: out_stall = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] phase_steps [0:4];
        int          p;
        int          k;
        in_valid       = 1'b0;
        op             = '0;
        particle_id    = '0;
        x_value        = '0;
        y_value        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        rst_n          = 1'b0;
        fail_count     = 0;
        burst_left     = 0;
        hold_requests  = 0;
        hold_served    = 0;
        particle_total = 0;
        step_q16       = TIME_STEP_RESET;
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            pos_x[k]  = 0;
            pos_y[k]  = 0;
            prev_x[k] = 0;
            prev_y[k] = 0;
            acc_x[k]  = 0;
            acc_y[k]  = 0;
        end

        add_row(OP_UPDATE,  8'd0,   24'sd0, 24'sd0, 1'b1, 8'd0,   24'sd0, 24'sd0, ST_NOT_INSERTED);
        add_row(OP_GET_VEL, 8'd255, CMAX,   CMIN,   1'b1, 8'd255, 24'sd0, 24'sd0, ST_NOT_INSERTED);
        add_row(OP_INSERT,  8'd77,  CMAX,   CMIN,   1'b1, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_INSERT,  8'd255, CMIN,   CMAX,   1'b1, 8'd1,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_INSERT,  8'd0,   24'sd0, 24'sd0, 1'b1, 8'd2,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_GET_VEL, 8'd0,   24'sd0, 24'sd0, 1'b1, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_SPARE_6, 8'd1,   CMAX,   CMAX,   1'b1, 8'd1,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_SPARE_7, 8'd200, CMIN,   CMIN,   1'b1, 8'd200, 24'sd0, 24'sd0, ST_OK);
        add_row(OP_ACCEL,   8'd0,   CMAX,   CMAX,   1'b1, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_ACCEL,   8'd0,   CMAX,   CMAX,   1'b1, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd0,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_SET_VEL, 8'd1,   CMAX,   CMIN,   1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_ADD_VEL, 8'd1,   CMIN,   CMAX,   1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd1,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_GET_VEL, 8'd1,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_ACCEL,   8'd2,   CMIN,   CMIN,   1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd2,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd2,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_SET_VEL, 8'd2,   -24'sd1, 24'sd1, 1'b0, 8'd0,  24'sd0, 24'sd0, ST_OK);
        add_row(OP_GET_VEL, 8'd2,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd3,   24'sd0, 24'sd0, 1'b1, 8'd3,   24'sd0, 24'sd0, ST_NOT_INSERTED);
        add_row(OP_ADD_VEL, 8'd2,   24'sd256, -24'sd256, 1'b0, 8'd0, 24'sd0, 24'sd0, ST_OK);
        add_row(OP_UPDATE,  8'd2,   24'sd0, 24'sd0, 1'b0, 8'd0,   24'sd0, 24'sd0, ST_OK);

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i]);
        go_idle();
        drain();

        phase_steps[0] = 16'hFFFF;
        phase_steps[1] = 16'h0000;
        phase_steps[2] = 16'($urandom());
        phase_steps[3] = 16'h0001;
        phase_steps[4] = 16'($urandom());
        for (p = 0; p < 5; p++)
        begin
            write_step(phase_steps[p]);
            if (p == 2)
            begin
                hold_requests++;
                burst_left = 60;
            end
            for (k = 0; k < 44; k++)
                offer_random(35);
            go_idle();
            drain();
        end

        // fill the table, then push inserts past the end
        write_step(TIME_STEP_RESET);
        while (particle_total < TABLE_DEPTH)
            offer_random(100);
        for (k = 0; k < 34; k++)
            offer_random(35);
        go_idle();
        drain();

        repeat (10)
            @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/vpi_pkg.sv
src/vpi_table.sv
src/vpi_alu.sv
src/verlet_particle_integrator_top.sv
dv/verlet_particle_integrator_top_tb.sv
